// ===== rtl/ifmt_pkg.sv =====
`default_nettype none
package ifmt_pkg;

	localparam int VALUE_W   = 32;
	localparam int OP_W      = 3;
	localparam int CHAR_W    = 8;
	localparam int NIB_W     = 4;
	localparam int DEC_DIGITS = 10;
	localparam int DIG_W     = DEC_DIGITS * NIB_W;
	localparam int CNT_W     = 5;
	localparam int DABBLE_STEPS = VALUE_W;
	localparam int HEX8_DIGITS = 8;
	localparam int HEX4_DIGITS = 4;
	localparam int HEX2_DIGITS = 2;

	// conversion modes
	typedef enum logic [OP_W-1:0] {
		OP_SDEC   = 3'd0,
		OP_UDEC   = 3'd1,
		OP_HEXMIN = 3'd2,
		OP_PTR    = 3'd3,
		OP_HEX2   = 3'd4,
		OP_HEX4   = 3'd5,
		OP_HEX8   = 3'd6,
		OP_CHAR   = 3'd7
	} op_t;

	// source of the output character
	typedef enum logic [2:0] {
		CH_MINUS,
		CH_ZERO,
		CH_X,
		CH_DIGIT,
		CH_RAW
	} char_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      dabble;
		logic      shift;
		char_sel_t sel;
	} ifmt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sign;
		logic top_zero;
	} ifmt_status_t;

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
	localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;

	// nibble to uppercase hex character
	function automatic logic [CHAR_W-1:0] hex_ascii(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < 4'd10) begin
			c = ASCII_ZERO + {4'd0, nib};
		end else begin
			c = ASCII_A + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ifmt_datapath.sv =====
`default_nettype none
module ifmt_datapath (
	input  wire logic                              clk,
	input  wire logic [ifmt_pkg::VALUE_W-1:0]      value,
	input  wire logic [ifmt_pkg::OP_W-1:0]         operation,
	input  wire ifmt_pkg::ifmt_cmd_t               cmd,
	output ifmt_pkg::ifmt_status_t                 status,
	output logic [ifmt_pkg::CHAR_W-1:0]            ascii_char
);

	logic [ifmt_pkg::VALUE_W-1:0] bin_q;
	logic [ifmt_pkg::DIG_W-1:0]   dig_q;
	logic [ifmt_pkg::DIG_W-1:0]   adj;
	logic [ifmt_pkg::DIG_W-1:0]   dig_load;
	logic [ifmt_pkg::VALUE_W-1:0] mag;
	logic [ifmt_pkg::NIB_W-1:0]   top_nib;

	// magnitude for decimal, raw value otherwise
	always_comb begin
		if (ifmt_pkg::op_t'(operation) == ifmt_pkg::OP_SDEC && value[ifmt_pkg::VALUE_W-1]) begin
			mag = (~value) + 32'd1;
		end else begin
			mag = value;
		end
	end

	// hex digits left aligned so the first digit sits in the top nibble
	always_comb begin
		case (ifmt_pkg::op_t'(operation))
			ifmt_pkg::OP_HEX2: begin
				dig_load = {value[7:0], 32'd0};
			end
			ifmt_pkg::OP_HEX4: begin
				dig_load = {value[15:0], 24'd0};
			end
			ifmt_pkg::OP_HEXMIN, ifmt_pkg::OP_PTR, ifmt_pkg::OP_HEX8: begin
				dig_load = {value, 8'd0};
			end
			default: begin
				dig_load = '0;
			end
		endcase
	end

	// add three to every bcd digit of five or more
	always_comb begin
		for (int i = 0; i < ifmt_pkg::DEC_DIGITS; i++) begin
			if (dig_q[i*ifmt_pkg::NIB_W +: ifmt_pkg::NIB_W] >= 4'd5) begin
				adj[i*ifmt_pkg::NIB_W +: ifmt_pkg::NIB_W] =
					dig_q[i*ifmt_pkg::NIB_W +: ifmt_pkg::NIB_W] + 4'd3;
			end else begin
				adj[i*ifmt_pkg::NIB_W +: ifmt_pkg::NIB_W] =
					dig_q[i*ifmt_pkg::NIB_W +: ifmt_pkg::NIB_W];
			end
		end
	end

	// binary and digit shift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			dig_q <= dig_load;
		end else if (cmd.dabble) begin
			dig_q <= {adj[ifmt_pkg::DIG_W-2:0], bin_q[ifmt_pkg::VALUE_W-1]};
			bin_q <= {bin_q[ifmt_pkg::VALUE_W-2:0], 1'b0};
		end else if (cmd.shift) begin
			dig_q <= {dig_q[ifmt_pkg::DIG_W-ifmt_pkg::NIB_W-1:0], {ifmt_pkg::NIB_W{1'b0}}};
		end
	end

	assign top_nib = dig_q[ifmt_pkg::DIG_W-1 -: ifmt_pkg::NIB_W];

	assign status.sign     = value[ifmt_pkg::VALUE_W-1];
	assign status.top_zero = (top_nib == '0);

	// output character select
	always_comb begin
		case (cmd.sel)
			ifmt_pkg::CH_MINUS: ascii_char = ifmt_pkg::ASCII_MINUS;
			ifmt_pkg::CH_ZERO:  ascii_char = ifmt_pkg::ASCII_ZERO;
			ifmt_pkg::CH_X:     ascii_char = ifmt_pkg::ASCII_X;
			ifmt_pkg::CH_RAW:   ascii_char = bin_q[ifmt_pkg::CHAR_W-1:0];
			default:            ascii_char = ifmt_pkg::hex_ascii(top_nib);
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/ifmt_ctrl.sv =====
`default_nettype none
module ifmt_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [ifmt_pkg::OP_W-1:0]    operation,
	input  wire ifmt_pkg::ifmt_status_t       status,
	output logic                              char_valid,
	input  wire logic                         char_ready,
	output logic                              last,
	output ifmt_pkg::ifmt_cmd_t               cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MINUS,
		ST_ZERO,
		ST_X,
		ST_DABBLE,
		ST_DIGITS,
		ST_RAW
	} state_t;

	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_ONE    = ifmt_pkg::CNT_W'(1);
	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_DABBLE = ifmt_pkg::CNT_W'(ifmt_pkg::DABBLE_STEPS - 1);
	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_DEC    = ifmt_pkg::CNT_W'(ifmt_pkg::DEC_DIGITS);
	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_HEX8   = ifmt_pkg::CNT_W'(ifmt_pkg::HEX8_DIGITS);
	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_HEX4   = ifmt_pkg::CNT_W'(ifmt_pkg::HEX4_DIGITS);
	localparam logic [ifmt_pkg::CNT_W-1:0] CNT_HEX2   = ifmt_pkg::CNT_W'(ifmt_pkg::HEX2_DIGITS);

	state_t                       state_q;
	logic [ifmt_pkg::CNT_W-1:0]   cnt_q;
	logic                         skip_q;
	logic                         accept;
	logic                         skipping;
	logic                         xfer;
	logic                         final_digit;

	// handshake and status decode
	always_comb begin
		item_ready  = (state_q == ST_IDLE);
		accept      = item_valid && item_ready;
		final_digit = (cnt_q == CNT_ONE);
		skipping    = (state_q == ST_DIGITS) && skip_q && status.top_zero && !final_digit;
		char_valid  = (state_q == ST_MINUS) || (state_q == ST_ZERO) || (state_q == ST_X)
			|| (state_q == ST_RAW) || ((state_q == ST_DIGITS) && !skipping);
		last        = (state_q == ST_RAW) || ((state_q == ST_DIGITS) && final_digit);
		xfer        = char_valid && char_ready;
	end

	// datapath commands
	always_comb begin
		cmd.load   = accept;
		cmd.dabble = (state_q == ST_DABBLE);
		cmd.shift  = skipping || ((state_q == ST_DIGITS) && xfer && !final_digit);
		case (state_q)
			ST_MINUS: cmd.sel = ifmt_pkg::CH_MINUS;
			ST_ZERO:  cmd.sel = ifmt_pkg::CH_ZERO;
			ST_X:     cmd.sel = ifmt_pkg::CH_X;
			ST_RAW:   cmd.sel = ifmt_pkg::CH_RAW;
			default:  cmd.sel = ifmt_pkg::CH_DIGIT;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			skip_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						skip_q <= 1'b0;
						case (ifmt_pkg::op_t'(operation))
							ifmt_pkg::OP_SDEC: begin
								cnt_q   <= CNT_DABBLE;
								state_q <= status.sign ? ST_MINUS : ST_DABBLE;
							end
							ifmt_pkg::OP_UDEC: begin
								cnt_q   <= CNT_DABBLE;
								state_q <= ST_DABBLE;
							end
							ifmt_pkg::OP_HEXMIN: begin
								cnt_q   <= CNT_HEX8;
								skip_q  <= 1'b1;
								state_q <= ST_DIGITS;
							end
							ifmt_pkg::OP_PTR: begin
								cnt_q   <= CNT_HEX8;
								state_q <= ST_ZERO;
							end
							ifmt_pkg::OP_HEX2: begin
								cnt_q   <= CNT_HEX2;
								state_q <= ST_DIGITS;
							end
							ifmt_pkg::OP_HEX4: begin
								cnt_q   <= CNT_HEX4;
								state_q <= ST_DIGITS;
							end
							ifmt_pkg::OP_HEX8: begin
								cnt_q   <= CNT_HEX8;
								state_q <= ST_DIGITS;
							end
							default: begin
								state_q <= ST_RAW;
							end
						endcase
					end
				end
				ST_MINUS: begin
					if (xfer) begin
						state_q <= ST_DABBLE;
					end
				end
				ST_ZERO: begin
					if (xfer) begin
						state_q <= ST_X;
					end
				end
				ST_X: begin
					if (xfer) begin
						state_q <= ST_DIGITS;
					end
				end
				ST_DABBLE: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_DEC;
						skip_q  <= 1'b1;
						state_q <= ST_DIGITS;
					end else begin
						cnt_q <= cnt_q - CNT_ONE;
					end
				end
				ST_DIGITS: begin
					if (skipping) begin
						cnt_q <= cnt_q - CNT_ONE;
					end else if (xfer) begin
						if (final_digit) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q  <= cnt_q - CNT_ONE;
							skip_q <= 1'b0;
						end
					end
				end
				ST_RAW: begin
					if (xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
`default_nettype none
// channel   handshake                payload
// item      item_valid/item_ready    value[31:0], operation[2:0]
// char      char_valid/char_ready    ascii_char[7:0], last
//
// one item at a time; item_ready is high only while the sequencer is idle
// decimal modes run a shift-and-add-3 bcd conversion over all 32 bits, then
// send from 10 digit slots, leading zeros dropped without being sent
// hex modes step through one nibble slot per digit; prefixes go one character at a time
// a stalled char_ready holds the current character and its sequencer state
// arst_n clears the sequencer only; the shift registers reload on every item
module integer_to_ascii_formatter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [31:0] value,
	input  wire logic [2:0]  operation,
	output logic             char_valid,
	input  wire logic        char_ready,
	output logic [7:0]       ascii_char,
	output logic             last
);

	ifmt_pkg::ifmt_cmd_t    cmd;
	ifmt_pkg::ifmt_status_t status;

	// sequencer
	ifmt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.operation  (operation),
		.status     (status),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.last       (last),
		.cmd        (cmd)
	);

	// conversion registers and character select
	ifmt_datapath u_datapath (
		.clk        (clk),
		.value      (value),
		.operation  (operation),
		.cmd        (cmd),
		.status     (status),
		.ascii_char (ascii_char)
	);

endmodule
`default_nettype wire
